### sv/tvwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwm_pkg
// shared types, codes and constants of the three-voice wavetable mixer
// ----------------------------------------------------------------------------
package tvwm_pkg;

   localparam int VOICE_COUNT = 3;
   localparam int VOICE_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

   localparam int OP_W        = 2;
   localparam int ADDR_W      = 8;
   localparam int NIBBLE_W    = 4;
   localparam int SAMPLE_W    = 16;
   localparam int SCALE_W     = 16;

   localparam int SREG_DEPTH  = 32;
   localparam int SREG_ADDR_W = 5;
   localparam int WAVE_DEPTH  = 256;
   localparam int WAVE_SEL_W  = 3;
   localparam int WAVE_POS_W  = 5;

   localparam int FREQ_W      = 20;
   localparam int PHASE_W     = 32;
   localparam int SUM_W       = 10;
   localparam int TOTAL_W     = 18;

   // shared multiplier operand and product widths
   localparam int MUL_A_W     = FREQ_W + 1;
   localparam int MUL_B_W     = SCALE_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   // sound register map
   localparam logic [SREG_ADDR_W-1:0] REG_WAVE_BASE = 5'h05;
   localparam logic [SREG_ADDR_W-1:0] REG_FREQ_LOW  = 5'h10;
   localparam logic [SREG_ADDR_W-1:0] REG_FREQ_BASE = 5'h11;
   localparam logic [SREG_ADDR_W-1:0] REG_VOL_BASE  = 5'h15;
   localparam int                     VOICE_STRIDE  = 5;
   localparam int                     FREQ_NIBBLES  = 4;

   localparam logic [SCALE_W-1:0]        SCALE_RESET = 16'd8192;
   localparam logic signed [MUL_B_W-1:0] MIX_GAIN    = 17'sd40;
   localparam logic signed [TOTAL_W-1:0] SAT_MAX     = 18'sd32767;
   localparam logic signed [TOTAL_W-1:0] SAT_MIN     = -18'sd32768;

   typedef enum logic [OP_W-1:0] {
      OP_REG_WRITE = 2'd0,
      OP_WAVE_LOAD = 2'd1,
      OP_TICK      = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VOICE_READ,
      ST_VOICE_PHASE,
      ST_VOICE_ACC,
      ST_MIX,
      ST_SAT
   } state_type;

endpackage

### sv/tvwm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwm_req_if
// request channel: register write, wave table load or sample tick
// ----------------------------------------------------------------------------
interface tvwm_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [tvwm_pkg::OP_W-1:0]              operation;
   logic [tvwm_pkg::ADDR_W-1:0]            address;
   logic [tvwm_pkg::NIBBLE_W-1:0]          write_data;
   logic signed [tvwm_pkg::SAMPLE_W-1:0]   mix_in;

   modport source (output valid, output operation, output address,
                   output write_data, output mix_in, input ready);
   modport sink   (input valid, input operation, input address,
                   input write_data, input mix_in, output ready);
endinterface

### sv/tvwm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwm_rsp_if
// response channel: one mixed sample per tick
// ----------------------------------------------------------------------------
interface tvwm_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tvwm_pkg::SAMPLE_W-1:0]   mixed_sample;

   modport source (output valid, output mixed_sample, input ready);
   modport sink   (input valid, input mixed_sample, output ready);
endinterface

### sv/three_voice_wavetable_mixer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_voice_wavetable_mixer_core
// three-voice wavetable generator mixed onto an incoming sample stream
// ----------------------------------------------------------------------------
// register writes and wave loads leave the sequencer in idle; ready stays high
// a tick runs the read, phase and accumulate states for each sounding voice, only
//    the read state for a silent one, then mix and saturation; ready low meanwhile
// the result sits in an output register; a new item is taken while it waits,
//    and a tick that finishes while it is still full holds in its last step
// synchronous reset clears sound registers, phases, phase scale (to 8192),
//    sequencer and output valid; the wave table is not cleared
module three_voice_wavetable_mixer_core (
   input  logic                              clock,
   input  logic                              reset,
   tvwm_req_if.sink                          req_chan,
   tvwm_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [tvwm_pkg::SCALE_W-1:0]      csr_write_data
);

   localparam int WAVE_ADDR_W = tvwm_pkg::WAVE_SEL_W + tvwm_pkg::WAVE_POS_W;

   // sequencer
   tvwm_pkg::state_type                        state_ff, state_in;
   logic [tvwm_pkg::VOICE_W-1:0]               voice_ff, voice_in;
   logic signed [tvwm_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic signed [tvwm_pkg::SAMPLE_W-1:0]       mix_ff;

   // storage
   logic [tvwm_pkg::NIBBLE_W-1:0]   sreg_ff  [tvwm_pkg::SREG_DEPTH];
   logic [tvwm_pkg::NIBBLE_W-1:0]   wave_mem [tvwm_pkg::WAVE_DEPTH];
   logic [tvwm_pkg::NIBBLE_W-1:0]   wave_rd_ff;
   logic [tvwm_pkg::PHASE_W-1:0]    phase_ff [tvwm_pkg::VOICE_COUNT];
   logic [tvwm_pkg::SCALE_W-1:0]    scale_ff;

   // result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [tvwm_pkg::SAMPLE_W-1:0] rsp_data_ff;

   // per-voice fields decoded from the sound registers
   logic [tvwm_pkg::FREQ_W-1:0]      freq   [tvwm_pkg::VOICE_COUNT];
   logic [tvwm_pkg::NIBBLE_W-1:0]    vol    [tvwm_pkg::VOICE_COUNT];
   logic [tvwm_pkg::WAVE_SEL_W-1:0]  wave   [tvwm_pkg::VOICE_COUNT];

   logic                                 accept;
   logic                                 voice_active;
   logic                                 last_voice;
   logic [WAVE_ADDR_W-1:0]               wave_rd_addr;
   logic signed [tvwm_pkg::NIBBLE_W-1:0] sample_centered;
   logic                                 phase_upd;
   logic                                 load_rsp;
   logic signed [tvwm_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [tvwm_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [tvwm_pkg::PROD_W-1:0]   prod;
   logic signed [tvwm_pkg::TOTAL_W-1:0]  total;
   logic signed [tvwm_pkg::SAMPLE_W-1:0] sat_sample;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == tvwm_pkg::ST_IDLE);

   // field decode: each voice field is tapped from a fixed sound register
   always_comb begin
      logic [tvwm_pkg::SREG_ADDR_W-1:0] base;
      logic [tvwm_pkg::FREQ_W-1:0]      f;
      for (int v = 0; v < tvwm_pkg::VOICE_COUNT; v++) begin
         base = tvwm_pkg::SREG_ADDR_W'(v * tvwm_pkg::VOICE_STRIDE);
         // voice 0 owns the lowest frequency nibble, the others read it as zero
         f = (v == 0) ? tvwm_pkg::FREQ_W'(sreg_ff[tvwm_pkg::REG_FREQ_LOW])
                      : '0;
         for (int k = 0; k < tvwm_pkg::FREQ_NIBBLES; k++) begin
            f[tvwm_pkg::NIBBLE_W*(k+1) +: tvwm_pkg::NIBBLE_W] =
               sreg_ff[base + tvwm_pkg::REG_FREQ_BASE
                       + tvwm_pkg::SREG_ADDR_W'(k)];
         end
         freq[v] = f;
         vol[v]  = sreg_ff[base + tvwm_pkg::REG_VOL_BASE];
         wave[v] = sreg_ff[base + tvwm_pkg::REG_WAVE_BASE][tvwm_pkg::WAVE_SEL_W-1:0];
      end
   end

   assign voice_active = (vol[voice_ff] != '0) && (freq[voice_ff] != '0);
   assign last_voice   = (voice_ff == tvwm_pkg::VOICE_W'(tvwm_pkg::VOICE_COUNT - 1));
   assign wave_rd_addr = {wave[voice_ff],
                          phase_ff[voice_ff][tvwm_pkg::PHASE_W-1 -: tvwm_pkg::WAVE_POS_W]};

   // stored nibble minus 8, as a 4-bit signed value
   assign sample_centered = {~wave_rd_ff[tvwm_pkg::NIBBLE_W-1],
                             wave_rd_ff[tvwm_pkg::NIBBLE_W-2:0]};

   // mix and saturate
   assign total = tvwm_pkg::TOTAL_W'(mix_ff) + prod[tvwm_pkg::TOTAL_W-1:0];
   always_comb begin
      if (total > tvwm_pkg::SAT_MAX) begin
         sat_sample = tvwm_pkg::SAMPLE_W'(tvwm_pkg::SAT_MAX);
      end else if (total < tvwm_pkg::SAT_MIN) begin
         sat_sample = tvwm_pkg::SAMPLE_W'(tvwm_pkg::SAT_MIN);
      end else begin
         sat_sample = total[tvwm_pkg::SAMPLE_W-1:0];
      end
   end

   // sequencer: next state, multiplier operands and datapath strobes
   always_comb begin
      state_in  = state_ff;
      voice_in  = voice_ff;
      sum_in    = sum_ff;
      mul_a     = '0;
      mul_b     = '0;
      phase_upd = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         tvwm_pkg::ST_IDLE: begin
            if (accept && (req_chan.operation == tvwm_pkg::OP_TICK)) begin
               state_in = tvwm_pkg::ST_VOICE_READ;
               voice_in = '0;
               sum_in   = '0;
            end
         end
         tvwm_pkg::ST_VOICE_READ: begin
            // wave read issued with the old phase; step = freq * scale
            mul_a = tvwm_pkg::MUL_A_W'(freq[voice_ff]);
            mul_b = tvwm_pkg::MUL_B_W'(scale_ff);
            if (voice_active) begin
               state_in = tvwm_pkg::ST_VOICE_PHASE;
            end else if (last_voice) begin
               state_in = tvwm_pkg::ST_MIX;
            end else begin
               voice_in = voice_ff + tvwm_pkg::VOICE_W'(1);
            end
         end
         tvwm_pkg::ST_VOICE_PHASE: begin
            phase_upd = 1'b1;
            mul_a     = tvwm_pkg::MUL_A_W'(vol[voice_ff]);
            mul_b     = tvwm_pkg::MUL_B_W'(sample_centered);
            state_in  = tvwm_pkg::ST_VOICE_ACC;
         end
         tvwm_pkg::ST_VOICE_ACC: begin
            sum_in = sum_ff + prod[tvwm_pkg::SUM_W-1:0];
            if (last_voice) begin
               state_in = tvwm_pkg::ST_MIX;
            end else begin
               voice_in = voice_ff + tvwm_pkg::VOICE_W'(1);
               state_in = tvwm_pkg::ST_VOICE_READ;
            end
         end
         tvwm_pkg::ST_MIX: begin
            mul_a    = tvwm_pkg::MUL_A_W'(sum_ff);
            mul_b    = tvwm_pkg::MIX_GAIN;
            state_in = tvwm_pkg::ST_SAT;
         end
         tvwm_pkg::ST_SAT: begin
            // same operands again so the product holds until the output register is free
            mul_a = tvwm_pkg::MUL_A_W'(sum_ff);
            mul_b = tvwm_pkg::MIX_GAIN;
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = tvwm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tvwm_pkg::ST_IDLE;
         end
      endcase
   end

   tvwm_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvwm_pkg::ST_IDLE;
         voice_ff <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         voice_ff <= voice_in;
         sum_ff   <= sum_in;
      end
   end

   // tick sample held for the mix step
   always_ff @(posedge clock) begin
      if (accept) begin
         mix_ff <= req_chan.mix_in;
      end
   end

   // sound registers: address bits above the register index are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tvwm_pkg::SREG_DEPTH; i++) begin
            sreg_ff[i] <= '0;
         end
      end else if (accept && (req_chan.operation == tvwm_pkg::OP_REG_WRITE)) begin
         sreg_ff[req_chan.address[tvwm_pkg::SREG_ADDR_W-1:0]] <= req_chan.write_data;
      end
   end

   // wave table memory, one write port, registered read
   always_ff @(posedge clock) begin
      if (accept && (req_chan.operation == tvwm_pkg::OP_WAVE_LOAD)) begin
         wave_mem[req_chan.address] <= req_chan.write_data;
      end
      wave_rd_ff <= wave_mem[wave_rd_addr];
   end

   // phase accumulators advance by the registered step, wrapping mod 2^32
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < tvwm_pkg::VOICE_COUNT; v++) begin
            phase_ff[v] <= '0;
         end
      end else if (phase_upd) begin
         phase_ff[voice_ff] <= phase_ff[voice_ff] + prod[tvwm_pkg::PHASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= tvwm_pkg::SCALE_RESET;
      end else if (csr_write_enable) begin
         scale_ff <= csr_write_data;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= sat_sample;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.mixed_sample = rsp_data_ff;

endmodule

### sv/tvwm_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvwm_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module tvwm_mul (
   input  logic                                  clock,
   input  logic signed [tvwm_pkg::MUL_A_W-1:0]   op_a,
   input  logic signed [tvwm_pkg::MUL_B_W-1:0]   op_b,
   output logic signed [tvwm_pkg::PROD_W-1:0]    prod_ff
);

   logic signed [tvwm_pkg::PROD_W-1:0] prod_in;

   assign prod_in = tvwm_pkg::PROD_W'(op_a) * tvwm_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the three-voice wavetable mixer: a queue-fed driver
// offers register writes, wave loads and sample ticks, a shadow of the sound
// registers, phases and wave table predicts every mixed sample, and a monitor
// compares each one as it leaves the block
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_LIMIT = 400000;
   localparam int WAVE_MID    = 8;
   localparam int WAVE_COUNT  = 1 << tvwm_pkg::WAVE_SEL_W;
   localparam int WAVE_LEN    = 1 << tvwm_pkg::WAVE_POS_W;
   localparam int SETTLE      = 16;   // longer than the slowest tick

   typedef struct packed {
      tvwm_pkg::op_type                     operation;
      logic [tvwm_pkg::ADDR_W-1:0]          address;
      logic [tvwm_pkg::NIBBLE_W-1:0]        write_data;
      logic signed [tvwm_pkg::SAMPLE_W-1:0] mix_in;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // locally held copies of every input, known from time zero
   logic                         req_valid        = 1'b0;
   req_item_type                 req_data         = '0;
   logic                         rsp_ready        = 1'b0;
   logic                         csr_write_enable = 1'b0;
   logic [tvwm_pkg::SCALE_W-1:0] csr_write_data   = '0;

   tvwm_req_if req_if ();
   tvwm_rsp_if rsp_if ();

   assign req_if.valid      = req_valid;
   assign req_if.operation  = req_data.operation;
   assign req_if.address    = req_data.address;
   assign req_if.write_data = req_data.write_data;
   assign req_if.mix_in     = req_data.mix_in;
   assign rsp_if.ready      = rsp_ready;

   three_voice_wavetable_mixer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block state, advanced as items are accepted
   logic [tvwm_pkg::NIBBLE_W-1:0] sreg_copy [tvwm_pkg::SREG_DEPTH] = '{default: '0};
   logic [tvwm_pkg::PHASE_W-1:0]  phase_acc [tvwm_pkg::VOICE_COUNT] = '{default: '0};
   logic [tvwm_pkg::NIBBLE_W-1:0] wave_mem  [tvwm_pkg::WAVE_DEPTH] = '{default: '0};
   logic [tvwm_pkg::SCALE_W-1:0]  scale_now = tvwm_pkg::SCALE_RESET;

   req_item_type                         queued_requests [$];
   logic signed [tvwm_pkg::SAMPLE_W-1:0] awaited_samples [$];
   logic signed [tvwm_pkg::SAMPLE_W-1:0] want;

   bit slice_ready [WAVE_COUNT];   // wave slices fully loaded by the stimulus
   bit idling_on   = 1'b1;
   int errors      = 0;
   int samples_seen = 0;
   int cycle_count = 0;
   int gap_left    = 0;
   int hold_left   = 0;
   bit long_hold_done = 1'b0;

   // one tick: sum the sounding voices, step their phases, mix and clamp
   function automatic logic signed [tvwm_pkg::SAMPLE_W-1:0] next_mixed_sample(
      input logic signed [tvwm_pkg::SAMPLE_W-1:0] mix);
      int                                           voice_total;
      int                                           total;
      int                                           base;
      logic [tvwm_pkg::FREQ_W-1:0]                  freq;
      logic [tvwm_pkg::NIBBLE_W-1:0]                vol;
      logic [tvwm_pkg::WAVE_SEL_W-1:0]              wave;
      logic [tvwm_pkg::ADDR_W-1:0]                  idx;
      logic [tvwm_pkg::FREQ_W+tvwm_pkg::SCALE_W-1:0] step;
      voice_total = 0;
      for (int v = 0; v < tvwm_pkg::VOICE_COUNT; v++) begin
         base = v * tvwm_pkg::VOICE_STRIDE;
         vol  = sreg_copy[(base + int'(tvwm_pkg::REG_VOL_BASE)) % tvwm_pkg::SREG_DEPTH];
         freq = '0;
         // only voice 0 owns the lowest frequency nibble
         if (v == 0) freq[tvwm_pkg::NIBBLE_W-1:0] = sreg_copy[tvwm_pkg::REG_FREQ_LOW];
         for (int k = 0; k < tvwm_pkg::FREQ_NIBBLES; k++)
            freq[tvwm_pkg::NIBBLE_W*(k+1) +: tvwm_pkg::NIBBLE_W] =
               sreg_copy[(base + int'(tvwm_pkg::REG_FREQ_BASE) + k) % tvwm_pkg::SREG_DEPTH];
         // silent voices hold their phase
         if (vol != 0 && freq != 0) begin
            wave = sreg_copy[(base + int'(tvwm_pkg::REG_WAVE_BASE)) % tvwm_pkg::SREG_DEPTH]
                            [tvwm_pkg::WAVE_SEL_W-1:0];
            idx  = {wave, phase_acc[v][tvwm_pkg::PHASE_W-1 -: tvwm_pkg::WAVE_POS_W]};
            voice_total += int'(vol) * (int'(wave_mem[idx]) - WAVE_MID);
            step = {{tvwm_pkg::SCALE_W{1'b0}}, freq} * {{tvwm_pkg::FREQ_W{1'b0}}, scale_now};
            phase_acc[v] += step[tvwm_pkg::PHASE_W-1:0];
         end
      end
      total = int'(mix) + voice_total * int'(tvwm_pkg::MIX_GAIN);
      if (total > int'(tvwm_pkg::SAT_MAX)) total = int'(tvwm_pkg::SAT_MAX);
      if (total < int'(tvwm_pkg::SAT_MIN)) total = int'(tvwm_pkg::SAT_MIN);
      return tvwm_pkg::SAMPLE_W'(total);
   endfunction

   // driver: updates the shadow on each accepted item, then offers the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_if.ready) begin
            case (req_data.operation)
               tvwm_pkg::OP_REG_WRITE:
                  sreg_copy[req_data.address[tvwm_pkg::SREG_ADDR_W-1:0]] = req_data.write_data;
               tvwm_pkg::OP_WAVE_LOAD:
                  wave_mem[req_data.address] = req_data.write_data;
               tvwm_pkg::OP_TICK:
                  awaited_samples.push_back(next_mixed_sample(req_data.mix_in));
               default: ;   // unused code, nothing happens
            endcase
         end
         if (!req_valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 18) - 1;
               req_valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               req_data  <= queued_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each mixed sample and throttles the result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_ready) begin
            samples_seen++;
            if (awaited_samples.size() == 0) begin
               errors++;
               $display("%0t mixed_sample: expected none, got %0d", $time,
                        rsp_if.mixed_sample);
            end else begin
               want = awaited_samples.pop_front();
               if (rsp_if.mixed_sample !== want) begin
                  errors++;
                  $display("%0t mixed_sample: expected %0d, got %0d", $time, want,
                           rsp_if.mixed_sample);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && samples_seen >= 5 && queued_requests.size() > 20) begin
            // long back-pressure while the driver keeps offering, so the block fills up
            long_hold_done = 1'b1;
            hold_left = 399;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CLOCK_LIMIT) begin
         $display("FAIL three_voice_wavetable_mixer_core");
         $finish;
      end
   end

   // load all entries of one wave slice; fill below zero means random nibbles
   task automatic queue_slice(input int wave, input int fill);
      req_item_type item;
      for (int i = 0; i < WAVE_LEN; i++) begin
         item.operation  = tvwm_pkg::OP_WAVE_LOAD;
         item.address    = tvwm_pkg::ADDR_W'(wave * WAVE_LEN + i);
         item.write_data = (fill < 0) ? tvwm_pkg::NIBBLE_W'($urandom)
                                      : tvwm_pkg::NIBBLE_W'(fill);
         item.mix_in     = tvwm_pkg::SAMPLE_W'($urandom);
         queued_requests.push_back(item);
      end
      slice_ready[wave] = 1'b1;
   endtask

   // a wave select never points at a slice that has not been fully loaded
   task automatic queue_item(input tvwm_pkg::op_type op, input int addr, input int data,
                             input int mix);
      req_item_type item;
      int           low5;
      low5 = addr % tvwm_pkg::SREG_DEPTH;
      if (op == tvwm_pkg::OP_REG_WRITE) begin
         for (int v = 0; v < tvwm_pkg::VOICE_COUNT; v++)
            if (low5 == int'(tvwm_pkg::REG_WAVE_BASE) + v * tvwm_pkg::VOICE_STRIDE &&
                !slice_ready[data % WAVE_COUNT])
               queue_slice(data % WAVE_COUNT, -1);
      end
      item.operation  = op;
      item.address    = tvwm_pkg::ADDR_W'(addr);
      item.write_data = tvwm_pkg::NIBBLE_W'(data);
      item.mix_in     = tvwm_pkg::SAMPLE_W'(mix);
      queued_requests.push_back(item);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || awaited_samples.size() != 0)
         @(negedge clock);
   endtask

   // phase scale changes only with nothing in flight
   task automatic set_scale(input logic [tvwm_pkg::SCALE_W-1:0] value);
      wait_idle();
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      scale_now = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(input int count);
      int pick;
      int mix;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 7))
            0:       mix = 32767;
            1:       mix = -32768;
            default: mix = $urandom_range(0, 65535);
         endcase
         if (pick < 38)
            queue_item(tvwm_pkg::OP_REG_WRITE, $urandom_range(0, 255),
                       $urandom_range(0, 15), mix);
         else if (pick < 50)
            queue_item(tvwm_pkg::OP_WAVE_LOAD, $urandom_range(0, 255),
                       $urandom_range(0, 15), mix);
         else if (pick < 96)
            queue_item(tvwm_pkg::OP_TICK, $urandom_range(0, 255),
                       $urandom_range(0, 15), mix);
         else
            queue_item(tvwm_pkg::OP_UNUSED, $urandom_range(0, 255),
                       $urandom_range(0, 15), mix);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // every voice starts on wave 0, so that slice goes in first, all at top level
      queue_slice(0, 15);

      // silent voices: the mix sample passes straight through, both extremes
      queue_item(tvwm_pkg::OP_TICK, 0, 0, 32767);
      queue_item(tvwm_pkg::OP_TICK, 8'hff, 15, -32768);
      // unused operation with every field bit set gives nothing
      queue_item(tvwm_pkg::OP_UNUSED, 8'hff, 15, -1);

      // voice 0 at full frequency and volume, high address bits set and ignored
      queue_item(tvwm_pkg::OP_REG_WRITE, 8'he0 | int'(tvwm_pkg::REG_FREQ_LOW), 15, 0);
      for (int k = 0; k < tvwm_pkg::FREQ_NIBBLES; k++)
         queue_item(tvwm_pkg::OP_REG_WRITE, int'(tvwm_pkg::REG_FREQ_BASE) + k, 15, 0);
      queue_item(tvwm_pkg::OP_REG_WRITE, 8'he0 | int'(tvwm_pkg::REG_VOL_BASE), 15, 0);
      queue_item(tvwm_pkg::OP_TICK, 0, 0, 32767);   // clamps high
      queue_item(tvwm_pkg::OP_TICK, 0, 0, 0);
      queue_item(tvwm_pkg::OP_REG_WRITE, int'(tvwm_pkg::REG_VOL_BASE), 0, 0);

      // voice 1 on a slice of zeros, wave select written with its top bit set
      queue_slice(1, 0);
      queue_item(tvwm_pkg::OP_REG_WRITE,
                 8'ha0 | (int'(tvwm_pkg::REG_WAVE_BASE) + tvwm_pkg::VOICE_STRIDE), 9, 0);
      for (int k = 0; k < tvwm_pkg::FREQ_NIBBLES; k++)
         queue_item(tvwm_pkg::OP_REG_WRITE,
                    int'(tvwm_pkg::REG_FREQ_BASE) + tvwm_pkg::VOICE_STRIDE + k, 15, 0);
      queue_item(tvwm_pkg::OP_REG_WRITE,
                 int'(tvwm_pkg::REG_VOL_BASE) + tvwm_pkg::VOICE_STRIDE, 15, 0);
      queue_item(tvwm_pkg::OP_TICK, 0, 0, -32768);   // clamps low
      queue_item(tvwm_pkg::OP_REG_WRITE,
                 int'(tvwm_pkg::REG_VOL_BASE) + tvwm_pkg::VOICE_STRIDE, 0, 0);

      // voice 2 at the smallest frequency and volume
      queue_item(tvwm_pkg::OP_REG_WRITE,
                 int'(tvwm_pkg::REG_WAVE_BASE) + 2 * tvwm_pkg::VOICE_STRIDE, 0, 0);
      queue_item(tvwm_pkg::OP_REG_WRITE,
                 int'(tvwm_pkg::REG_FREQ_BASE) + 2 * tvwm_pkg::VOICE_STRIDE, 1, 0);
      queue_item(tvwm_pkg::OP_REG_WRITE,
                 int'(tvwm_pkg::REG_VOL_BASE) + 2 * tvwm_pkg::VOICE_STRIDE, 1, 0);
      queue_item(tvwm_pkg::OP_TICK, 0, 0, 0);
      queue_item(tvwm_pkg::OP_TICK, 0, 0, -1);

      // random traffic over several phase scales
      run_random(60);
      set_scale(16'hffff);
      run_random(50);
      idling_on = 1'b0;
      set_scale(16'd1);
      run_random(40);
      idling_on = 1'b1;
      set_scale(16'd0);   // phases freeze while voices keep sounding
      run_random(30);
      set_scale(tvwm_pkg::SCALE_W'($urandom));
      run_random(40);
      // last part runs with no idling on either side
      set_scale(tvwm_pkg::SCALE_W'($urandom));
      idling_on = 1'b0;
      run_random(30);

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("PASS three_voice_wavetable_mixer_core");
      else
         $display("FAIL three_voice_wavetable_mixer_core");
      $finish;
   end

endmodule
